>>> rtl/core/zone_black_density_macros.svh
// Assertion macros for the checker file of zone_black_density.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ZONE_BLACK_DENSITY_MACROS_SVH
`define ZONE_BLACK_DENSITY_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ZBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zone_black_density: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define ZBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zone_black_density: next-cycle check failed");

`endif

>>> rtl/core/zbd_pkg.sv
package zbd_pkg;

  localparam int GRID_SIZE     = 10;
  localparam int MAX_DIMENSION = 4096;

  // Field widths fixed by the interface.
  localparam int CFG_W    = 13;
  localparam int COLOR_W  = 8;
  localparam int FIELD_W  = 4;
  localparam int DENS_W   = 16;
  localparam int FRAC_BITS = 15;
  localparam int DENSITY_ONE = 1 << FRAC_BITS;

  // Internal widths.
  localparam int DIM_W      = $clog2(MAX_DIMENSION + 1);
  localparam int POS_W      = $clog2(MAX_DIMENSION);
  localparam int ZONE_W     = $clog2(MAX_DIMENSION / GRID_SIZE + 1);
  localparam int GRID_IDX_W = $clog2(GRID_SIZE + 1);
  localparam int CNT_IDX_W  = $clog2(GRID_SIZE);
  localparam int AREA_W     = 2 * ZONE_W;
  localparam int COUNT_W    = AREA_W;
  localparam int REM_W      = AREA_W + 1;
  localparam int DIV_STEPS  = DENS_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Division by the grid size as a multiply by a rounded-up reciprocal.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + GRID_SIZE - 1) / GRID_SIZE;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = DIM_W + RECIP_W;

  localparam int DIM_RESET = 100;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FIELD_W-1:0] zone_column;
    logic [FIELD_W-1:0] zone_row;
    logic [DENS_W-1:0]  density;
    logic               last_of_band;
  } result_t;

endpackage

>>> rtl/core/zone_black_density.sv
// Channel   Direction  Handshake              Word
// in_       input      in_valid / in_stall    zbd_pkg::pixel_t, one RGB pixel in raster order
// out_      output     out_valid / out_stall  zbd_pkg::result_t, one zone density
// cfg_      input      cfg_we                 cfg_index selects image_width or image_height
//
// A pixel is taken every cycle while no band is being reported.
// At the last pixel of a zone band the block stops taking pixels and runs one shared
// restoring divider: per zone a load state, 16 divide steps and an output state that
// holds while out_stall is high; the next pixel is taken once all ten zones are out.
// Reset is synchronous and active low; it restores both dimensions to 100.
// A stalled result holds in the output register until the receiver takes it.
module zone_black_density (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  zbd_pkg::pixel_t             in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output zbd_pkg::result_t            out_data,
  input  logic                        cfg_we,
  input  zbd_pkg::cfg_reg_t           cfg_index,
  input  logic [zbd_pkg::CFG_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  function automatic logic [zbd_pkg::DIM_W-1:0] clamp_dim(
    input logic [zbd_pkg::CFG_W-1:0] v
  );
    logic [zbd_pkg::DIM_W-1:0] res;
    if (v == '0) begin
      res = zbd_pkg::DIM_W'(1);
    end else if (int'(v) > zbd_pkg::MAX_DIMENSION) begin
      res = zbd_pkg::DIM_W'(zbd_pkg::MAX_DIMENSION);
    end else begin
      res = zbd_pkg::DIM_W'(v);
    end
    return res;
  endfunction

  function automatic logic [zbd_pkg::ZONE_W-1:0] div_grid(
    input logic [zbd_pkg::DIM_W-1:0] v
  );
    logic [zbd_pkg::PROD_W-1:0] prod;
    prod = zbd_pkg::PROD_W'(v) * zbd_pkg::PROD_W'(zbd_pkg::RECIP);
    return prod[zbd_pkg::RECIP_SHIFT +: zbd_pkg::ZONE_W];
  endfunction

  state_t                            state_r;
  logic [zbd_pkg::DIM_W-1:0]         w_r;
  logic [zbd_pkg::DIM_W-1:0]         h_r;
  logic [zbd_pkg::ZONE_W-1:0]        zw_r;
  logic [zbd_pkg::ZONE_W-1:0]        zh_r;
  logic [zbd_pkg::AREA_W-1:0]        area_r;
  logic [zbd_pkg::POS_W-1:0]         col_r;
  logic [zbd_pkg::POS_W-1:0]         row_r;
  logic [zbd_pkg::ZONE_W-1:0]        sub_col_r;
  logic [zbd_pkg::ZONE_W-1:0]        sub_row_r;
  logic [zbd_pkg::GRID_IDX_W-1:0]    zx_r;
  logic [zbd_pkg::GRID_IDX_W-1:0]    band_r;
  logic [zbd_pkg::COUNT_W-1:0]       counts_r [zbd_pkg::GRID_SIZE];
  logic [zbd_pkg::FIELD_W-1:0]       zone_r;
  logic [zbd_pkg::FIELD_W-1:0]       band_out_r;
  logic [zbd_pkg::STEP_W-1:0]        step_r;
  logic [zbd_pkg::REM_W-1:0]         rem_r;
  logic [zbd_pkg::DENS_W-1:0]        quo_r;
  zbd_pkg::result_t                  out_data_r;

  logic                              in_fire;
  logic                              black;
  logic                              col_last;
  logic                              row_last;
  logic                              sub_col_last;
  logic                              sub_row_last;
  logic                              in_rows;
  logic                              in_cols;
  logic                              emit;
  logic                              count_en;
  logic                              zone_last;
  logic                              ge;
  logic [zbd_pkg::REM_W-1:0]         diff;
  logic [zbd_pkg::REM_W-1:0]         rem_nxt;
  logic [zbd_pkg::DENS_W-1:0]        quo_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_data_r;

  assign black = (in_data.red == '0) && (in_data.green == '0) && (in_data.blue == '0);
  assign col_last     = (zbd_pkg::DIM_W'(col_r) == w_r - zbd_pkg::DIM_W'(1));
  assign row_last     = (zbd_pkg::DIM_W'(row_r) == h_r - zbd_pkg::DIM_W'(1));
  assign sub_col_last = (sub_col_r == zw_r - zbd_pkg::ZONE_W'(1));
  assign sub_row_last = (sub_row_r == zh_r - zbd_pkg::ZONE_W'(1));
  assign in_rows  = (zh_r != '0) && (band_r < zbd_pkg::GRID_IDX_W'(zbd_pkg::GRID_SIZE));
  assign in_cols  = (zw_r != '0) && (zx_r < zbd_pkg::GRID_IDX_W'(zbd_pkg::GRID_SIZE));
  assign emit     = in_rows && col_last && sub_row_last;
  assign count_en = in_fire && in_rows && in_cols && black;
  assign zone_last = (zone_r == zbd_pkg::FIELD_W'(zbd_pkg::GRID_SIZE - 1));

  // One restoring step: the quotient never exceeds one, so the count itself is the
  // starting remainder and sixteen steps give the Q1.15 result.
  assign ge      = (area_r != '0) && (rem_r >= zbd_pkg::REM_W'(area_r));
  assign diff    = ge ? (rem_r - zbd_pkg::REM_W'(area_r)) : rem_r;
  assign rem_nxt = {diff[zbd_pkg::REM_W-2:0], 1'b0};
  assign quo_nxt = {quo_r[zbd_pkg::DENS_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      w_r        <= clamp_dim(zbd_pkg::CFG_W'(zbd_pkg::DIM_RESET));
      h_r        <= clamp_dim(zbd_pkg::CFG_W'(zbd_pkg::DIM_RESET));
      zw_r       <= div_grid(clamp_dim(zbd_pkg::CFG_W'(zbd_pkg::DIM_RESET)));
      zh_r       <= div_grid(clamp_dim(zbd_pkg::CFG_W'(zbd_pkg::DIM_RESET)));
      col_r      <= '0;
      row_r      <= '0;
      sub_col_r  <= '0;
      sub_row_r  <= '0;
      zx_r       <= '0;
      band_r     <= '0;
      zone_r     <= '0;
      band_out_r <= '0;
      for (int i = 0; i < zbd_pkg::GRID_SIZE; i++) begin
        counts_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        zbd_pkg::REG_IMAGE_WIDTH: begin
          w_r  <= clamp_dim(cfg_data);
          zw_r <= div_grid(clamp_dim(cfg_data));
        end
        zbd_pkg::REG_IMAGE_HEIGHT: begin
          h_r  <= clamp_dim(cfg_data);
          zh_r <= div_grid(clamp_dim(cfg_data));
        end
        default: begin
          w_r <= w_r;
        end
      endcase
      // Any register write starts a new image.
      col_r     <= '0;
      row_r     <= '0;
      sub_col_r <= '0;
      sub_row_r <= '0;
      zx_r      <= '0;
      band_r    <= '0;
      for (int i = 0; i < zbd_pkg::GRID_SIZE; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (count_en) begin
              counts_r[zx_r[zbd_pkg::CNT_IDX_W-1:0]] <=
                counts_r[zx_r[zbd_pkg::CNT_IDX_W-1:0]] + zbd_pkg::COUNT_W'(1);
            end
            if (emit) begin
              state_r    <= S_LOAD;
              zone_r     <= '0;
              band_out_r <= zbd_pkg::FIELD_W'(band_r);
            end
            if (col_last) begin
              col_r     <= '0;
              sub_col_r <= '0;
              zx_r      <= '0;
              if (row_last) begin
                row_r     <= '0;
                sub_row_r <= '0;
                band_r    <= '0;
                // Without a band report pending, the image end drops the counts.
                if (!emit) begin
                  for (int i = 0; i < zbd_pkg::GRID_SIZE; i++) begin
                    counts_r[i] <= '0;
                  end
                end
              end else begin
                row_r <= row_r + zbd_pkg::POS_W'(1);
                if (band_r < zbd_pkg::GRID_IDX_W'(zbd_pkg::GRID_SIZE)) begin
                  if (sub_row_last) begin
                    sub_row_r <= '0;
                    band_r    <= band_r + zbd_pkg::GRID_IDX_W'(1);
                  end else begin
                    sub_row_r <= sub_row_r + zbd_pkg::ZONE_W'(1);
                  end
                end
              end
            end else begin
              col_r <= col_r + zbd_pkg::POS_W'(1);
              if (zx_r < zbd_pkg::GRID_IDX_W'(zbd_pkg::GRID_SIZE)) begin
                if (sub_col_last) begin
                  sub_col_r <= '0;
                  zx_r      <= zx_r + zbd_pkg::GRID_IDX_W'(1);
                end else begin
                  sub_col_r <= sub_col_r + zbd_pkg::ZONE_W'(1);
                end
              end
            end
          end
        end
        S_LOAD: begin
          // The counts shift down one zone per report, so the band ends cleared.
          for (int i = 0; i < zbd_pkg::GRID_SIZE - 1; i++) begin
            counts_r[i] <= counts_r[i+1];
          end
          counts_r[zbd_pkg::GRID_SIZE-1] <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (step_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (zone_last) begin
              state_r <= S_IDLE;
            end else begin
              zone_r  <= zone_r + zbd_pkg::FIELD_W'(1);
              state_r <= S_LOAD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    area_r <= zbd_pkg::AREA_W'(zw_r) * zbd_pkg::AREA_W'(zh_r);
    if (state_r == S_LOAD) begin
      rem_r  <= zbd_pkg::REM_W'(counts_r[0]);
      quo_r  <= '0;
      step_r <= zbd_pkg::STEP_W'(zbd_pkg::DIV_STEPS - 1);
    end else if (state_r == S_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r - zbd_pkg::STEP_W'(1);
      if (step_r == '0) begin
        out_data_r.zone_column  <= zone_r;
        out_data_r.zone_row     <= band_out_r;
        out_data_r.density      <= quo_nxt;
        out_data_r.last_of_band <= zone_last;
      end
    end
  end

endmodule

>>> rtl/core/zbd_checker.sv
`include "zone_black_density_macros.svh"

module zbd_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input zbd_pkg::result_t out_data
);

  logic result_in_range;
  logic last_on_edge;

  assign result_in_range =
    (out_data.density <= zbd_pkg::DENS_W'(zbd_pkg::DENSITY_ONE)) &&
    (out_data.zone_column <= zbd_pkg::FIELD_W'(zbd_pkg::GRID_SIZE - 1)) &&
    (out_data.zone_row <= zbd_pkg::FIELD_W'(zbd_pkg::GRID_SIZE - 1));
  assign last_on_edge =
    (out_data.last_of_band ==
     (out_data.zone_column == zbd_pkg::FIELD_W'(zbd_pkg::GRID_SIZE - 1)));

  // A waiting result word holds its value.
  `ZBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // No pixel is taken while a band is being reported.
  `ZBD_ASSERT_IMPL(a_no_pixel_during_report, out_valid, in_stall)

  // After a word that does not close its band, the report goes on.
  `ZBD_ASSERT_NEXT(a_band_goes_on, out_valid && !out_stall && !out_data.last_of_band, in_stall)

  // Zone indexes stay in the grid and density never passes one.
  `ZBD_ASSERT_IMPL(a_result_range, out_valid, result_in_range)

  // The band closes exactly on its rightmost zone.
  `ZBD_ASSERT_IMPL(a_last_on_right_edge, out_valid, last_on_edge)

endmodule

bind zone_black_density zbd_checker u_zbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/tb_zone_black_density.sv
module tb_zone_black_density;

  localparam int SETTLE_CYCLES = 250;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int NUM_PHASES    = 9;

  typedef enum logic {
    ROW_CFG,
    ROW_PIX
  } row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    zbd_pkg::cfg_reg_t                idx;
    logic [zbd_pkg::CFG_W-1:0]        val;
    zbd_pkg::pixel_t                  px;
    logic                             typed;
    logic [zbd_pkg::DENS_W-1:0]       dens;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  zbd_pkg::pixel_t           in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  zbd_pkg::result_t          out_data;
  logic                      cfg_we = 1'b0;
  zbd_pkg::cfg_reg_t         cfg_index = zbd_pkg::REG_IMAGE_WIDTH;
  logic [zbd_pkg::CFG_W-1:0] cfg_data = '0;

  // Shadow of the block: dimensions, raster position and black counts of the band.
  logic [zbd_pkg::CFG_W-1:0] width_reg = zbd_pkg::CFG_W'(zbd_pkg::DIM_RESET);
  logic [zbd_pkg::CFG_W-1:0] height_reg = zbd_pkg::CFG_W'(zbd_pkg::DIM_RESET);
  int                        pos_col = 0;
  int                        pos_row = 0;
  int                        zone_black [zbd_pkg::GRID_SIZE];

  zbd_pkg::result_t          pending_zones [$];
  zbd_pkg::result_t          got;
  zbd_pkg::result_t          want;
  int                        errs = 0;
  int                        burst_left = 0;
  int                        cycle_count = 0;
  int                        stall_mode = 0;
  int                        stall_left = 0;
  stim_row_t                 dir_rows [$];

  int phase_w   [NUM_PHASES] = '{10, 23, 30, 8191, 1, 15, 9, 12, 20};
  int phase_h   [NUM_PHASES] = '{10, 17, 20, 10, 8191, 12, 30, 9, 10};
  int phase_n   [NUM_PHASES] = '{20, 30, 60, 8, 8, 15, 27, 9, 20};
  int phase_pct [NUM_PHASES] = '{50, 60, 40, 70, 50, 90, 50, 50, 100};

  zone_black_density u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int usable_dim(logic [zbd_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > zbd_pkg::MAX_DIMENSION) return zbd_pkg::MAX_DIMENSION;
    return int'(v);
  endfunction

  function automatic void clear_counts();
    foreach (zone_black[k]) zone_black[k] = 0;
  endfunction

  // Advances the shadow by one pixel and queues the ten zone words of a finished band.
  task automatic count_pixel(zbd_pkg::pixel_t px, logic typed,
                             logic [zbd_pkg::DENS_W-1:0] typed_dens);
    int               w, h, zw, zh, col, row, i;
    logic             black, in_rows;
    longint           area, dens;
    zbd_pkg::result_t r;
    w = usable_dim(width_reg);
    h = usable_dim(height_reg);
    zw = w / zbd_pkg::GRID_SIZE;
    zh = h / zbd_pkg::GRID_SIZE;
    col = (pos_col >= w) ? 0 : pos_col;
    row = (pos_row >= h) ? 0 : pos_row;
    black = (px.red == 0) && (px.green == 0) && (px.blue == 0);
    in_rows = (zh != 0) && (row < zh * zbd_pkg::GRID_SIZE);
    if (in_rows && zw != 0 && col < zw * zbd_pkg::GRID_SIZE && black) zone_black[col / zw]++;
    if (in_rows && col == w - 1 && (row % zh) == zh - 1) begin
      area = longint'(zw) * longint'(zh);
      for (i = 0; i < zbd_pkg::GRID_SIZE; i++) begin
        dens = (area == 0) ? 0 : (longint'(zone_black[i]) << zbd_pkg::FRAC_BITS) / area;
        if (dens > zbd_pkg::DENSITY_ONE) dens = zbd_pkg::DENSITY_ONE;
        r.zone_column = zbd_pkg::FIELD_W'(i);
        r.zone_row = zbd_pkg::FIELD_W'(row / zh);
        r.density = typed ? typed_dens : zbd_pkg::DENS_W'(dens);
        r.last_of_band = (i == zbd_pkg::GRID_SIZE - 1);
        pending_zones = {pending_zones, r};
      end
      clear_counts();
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) begin
        row = 0;
        clear_counts();
      end
    end
    pos_col = col;
    pos_row = row;
  endtask

  function automatic zbd_pkg::pixel_t rand_pixel(int pct);
    zbd_pkg::pixel_t p;
    p = '0;
    if ($urandom_range(0, 99) >= pct) begin
      case ($urandom_range(0, 3))
        0: p = 24'($urandom);
        1: p.red = 8'($urandom_range(1, 255));
        2: p.green = 8'($urandom_range(1, 255));
        default: p.blue = 8'($urandom_range(1, 255));
      endcase
    end
    return p;
  endfunction

  function automatic stim_row_t cfg_row(zbd_pkg::cfg_reg_t idx, int val);
    stim_row_t s;
    s = '0;
    s.kind = ROW_CFG;
    s.idx = idx;
    s.val = zbd_pkg::CFG_W'(val);
    return s;
  endfunction

  function automatic stim_row_t pix_row(int r, int g, int b, logic typed, int dens);
    stim_row_t s;
    s = '0;
    s.kind = ROW_PIX;
    s.px = '{8'(r), 8'(g), 8'(b)};
    s.typed = typed;
    s.dens = zbd_pkg::DENS_W'(dens);
    return s;
  endfunction

  task automatic add_row(stim_row_t s);
    dir_rows = {dir_rows, s};
  endtask

  // Called just after a falling edge; returns just after the falling edge that follows the taking of the pixel.
  task automatic drive_pixel(zbd_pkg::pixel_t px, logic typed,
                             logic [zbd_pkg::DENS_W-1:0] dens);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    count_pixel(px, typed, dens);
    burst_left--;
    @(negedge clk);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic pause_sender();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic settle(logic tail);
    pause_sender();
    while (pending_zones.size() != 0) @(negedge clk);
    if (tail) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A dimension write restarts the image, so the shadow position and counts go to zero.
  task automatic set_dim(zbd_pkg::cfg_reg_t idx, logic [zbd_pkg::CFG_W-1:0] val);
    settle(1'b1);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == zbd_pkg::REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    pos_col = 0;
    pos_row = 0;
    clear_counts();
  endtask

  task automatic random_pixels(int n, int pct);
    int i;
    for (i = 0; i < n; i++) begin
      if (i == n / 2) settle(1'b0);
      drive_pixel(rand_pixel(pct), 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((stall_left % 8) < 5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      if (pending_zones.size() == 0) begin
        errs++;
        if (errs <= 40)
          $display("%0t: unexpected zone word col %0d row %0d density %0d last %0b",
                   $time, got.zone_column, got.zone_row, got.density, got.last_of_band);
      end else begin
        want = pending_zones.pop_front();
        if (got.zone_column !== want.zone_column || got.zone_row !== want.zone_row ||
            got.density !== want.density || got.last_of_band !== want.last_of_band) begin
          errs++;
          if (errs <= 40)
            $display({"%0t: expected col %0d row %0d density %0d last %0b, ",
                      "got col %0d row %0d density %0d last %0b"},
                     $time, want.zone_column, want.zone_row, want.density,
                     want.last_of_band, got.zone_column, got.zone_row, got.density,
                     got.last_of_band);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_zone_black_density: errors");
      $finish;
    end
  end

  initial begin
    clear_counts();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // At the reset size of 100 by 100 a band takes 1000 pixels, so a few give no word.
    random_pixels(4, 50);

    // One pixel per zone: an all-black band reads full density in every zone.
    add_row(cfg_row(zbd_pkg::REG_IMAGE_WIDTH, 10));
    add_row(cfg_row(zbd_pkg::REG_IMAGE_HEIGHT, 10));
    repeat (9) add_row(pix_row(0, 0, 0, 1'b0, 0));
    add_row(pix_row(0, 0, 0, 1'b1, zbd_pkg::DENSITY_ONE));
    add_row(pix_row(255, 255, 255, 1'b0, 0));
    add_row(pix_row(0, 0, 0, 1'b0, 0));
    add_row(pix_row(1, 0, 0, 1'b0, 0));
    add_row(pix_row(0, 1, 0, 1'b0, 0));
    add_row(pix_row(0, 0, 1, 1'b0, 0));
    add_row(pix_row(128, 0, 0, 1'b0, 0));
    add_row(pix_row(0, 128, 0, 1'b0, 0));
    add_row(pix_row(0, 0, 128, 1'b0, 0));
    add_row(pix_row(0, 0, 0, 1'b0, 0));
    add_row(pix_row(255, 0, 255, 1'b0, 0));
    // A width of zero is taken as one; zones have no width and every density is zero.
    add_row(cfg_row(zbd_pkg::REG_IMAGE_WIDTH, 0));
    add_row(pix_row(0, 0, 0, 1'b1, 0));
    // With no whole zone row in the image no band ever finishes.
    add_row(cfg_row(zbd_pkg::REG_IMAGE_HEIGHT, 0));
    add_row(pix_row(0, 0, 0, 1'b0, 0));
    add_row(pix_row(255, 255, 255, 1'b0, 0));

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) set_dim(dir_rows[k].idx, dir_rows[k].val);
      else drive_pixel(dir_rows[k].px, dir_rows[k].typed, dir_rows[k].dens);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_dim(zbd_pkg::REG_IMAGE_WIDTH, zbd_pkg::CFG_W'(phase_w[p]));
      set_dim(zbd_pkg::REG_IMAGE_HEIGHT, zbd_pkg::CFG_W'(phase_h[p]));
      random_pixels(phase_n[p], phase_pct[p]);
    end

    settle(1'b1);
    if (errs == 0) begin
      $display("tb_zone_black_density: clean");
    end else begin
      $display("tb_zone_black_density: errors");
    end
    $finish;
  end

endmodule

>>> zone_black_density.f
+incdir+rtl/core
rtl/core/zbd_pkg.sv
rtl/core/zone_black_density.sv
rtl/core/zbd_checker.sv
test/tb_zone_black_density.sv
